### rtl/core/plm_pkg.sv
// Shared constants and types for the pragma line matcher.
`timescale 1ns / 1ps
`default_nettype none

package plm_pkg;

   localparam int TEXT_W     = 8;
   localparam int LINE_W     = 24;
   localparam int INDEX_W    = 4;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 1;
   localparam int KWLEN_W    = 4;
   localparam int PRAGMA_LEN = 6;

   localparam logic [TEXT_W-1:0] CHAR_NUL     = 8'd0;
   localparam logic [TEXT_W-1:0] CHAR_TAB     = 8'd9;
   localparam logic [TEXT_W-1:0] CHAR_NEWLINE = 8'd10;
   localparam logic [TEXT_W-1:0] CHAR_SPACE   = 8'd32;
   localparam logic [TEXT_W-1:0] CHAR_HASH    = 8'd35;

   // "pragma", first character in the low byte
   localparam logic [PRAGMA_LEN*TEXT_W-1:0] PRAGMA_WORD = 48'h61_6D_67_61_72_70;

   localparam logic [LINE_W-1:0] LINE_MAX = 24'hFF_FFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEYWORD_BYTES  = 1'b0,
      CSR_KEYWORD_LENGTH = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      KIND_ARG = 1'b0,
      KIND_END = 1'b1
   } kind_type;

endpackage

`default_nettype wire

### rtl/core/plm_if.sv
// Valid/ready channel interfaces for text bytes in and argument items out.
`timescale 1ns / 1ps
`default_nettype none

interface plm_req_if;
   logic                       valid;
   logic                       ready;
   logic [plm_pkg::TEXT_W-1:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface

interface plm_rsp_if;
   logic                       valid;
   logic                       ready;
   plm_pkg::kind_type          item_kind;
   logic [plm_pkg::TEXT_W-1:0] arg_byte;
   logic [plm_pkg::LINE_W-1:0] line_number;

   modport source (output valid, output item_kind, output arg_byte, output line_number,
                   input ready);
   modport sink   (input valid, input item_kind, input arg_byte, input line_number,
                   output ready);
endinterface

`default_nettype wire

### rtl/core/pragma_line_matcher.sv
// Top level: pragma line scanner with input register and result register.
// The block takes one text byte per cycle and scans it against the pattern
// [blanks] '#' [blanks] "pragma" blank+ keyword blank+ argument. Each byte is
// held in an input register, run through the scanner state and,
// on a matching line, written to the result register as an argument byte or,
// on the newline, as an end marker; a result passes the input register and
// the result register before it is offered. The sustained rate is one byte
// per clock, set by the single scanner state register that every byte updates;
// it drops only while the result register is full and not taken. The user must
// write keyword registers via the csr_ port while idle; the block does not check.
`timescale 1ns / 1ps
`default_nettype none

module pragma_line_matcher #(
   parameter int KEYWORD_MAX = 8
) (
   input  wire                                 clock,
   input  wire                                 reset,
   plm_req_if.sink                             req_bus,
   plm_rsp_if.source                           rsp_bus,
   input  wire                                 csr_we,
   input  wire [plm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire [plm_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int KW_W = KEYWORD_MAX * plm_pkg::TEXT_W;

   typedef enum logic [3:0] {
      PH_LEAD       = 4'd0,
      PH_POSTHASH   = 4'd1,
      PH_PRAGMA     = 4'd2,
      PH_NEEDBLANK1 = 4'd3,
      PH_SKIP1      = 4'd4,
      PH_KEYWORD    = 4'd5,
      PH_NEEDBLANK2 = 4'd6,
      PH_SKIP2      = 4'd7,
      PH_ARG        = 4'd8,
      PH_ARGCUT     = 4'd9,
      PH_DEAD       = 4'd10
   } phase_type;

   logic [KW_W-1:0]                    kw_ff;
   logic [plm_pkg::KWLEN_W-1:0]        kwlen_ff;
   phase_type                          phase_ff, phase_in;
   logic [plm_pkg::INDEX_W-1:0]        index_ff, index_in;
   logic [plm_pkg::LINE_W-1:0]         line_ff, line_in;
   logic                               in_valid_ff;
   logic [plm_pkg::TEXT_W-1:0]         in_byte_ff;
   logic                               out_valid_ff, out_valid_in;
   plm_pkg::kind_type                  out_kind_ff, out_kind_in;
   logic [plm_pkg::TEXT_W-1:0]         out_byte_ff, out_byte_in;
   logic [plm_pkg::LINE_W-1:0]         out_line_ff, out_line_in;

   logic                               advance;
   logic                               res_valid;
   logic [plm_pkg::KWLEN_W-1:0]        len_cap;
   logic [plm_pkg::KWLEN_W-1:0]        klen;
   logic [plm_pkg::INDEX_W-1:0]        kw_idx;
   logic [plm_pkg::TEXT_W-1:0]         kw_char;
   logic [plm_pkg::TEXT_W-1:0]         pragma_char;
   logic [plm_pkg::LINE_W-1:0]         cur_line;
   logic                               is_blank;
   logic                               kw_hit;
   logic [plm_pkg::INDEX_W-1:0]        kw_next;

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.item_kind   = out_kind_ff;
   assign rsp_bus.arg_byte    = out_byte_ff;
   assign rsp_bus.line_number = out_line_ff;

   // effective keyword length: capped, cut at the first zero byte
   always_comb begin
      len_cap = (kwlen_ff > plm_pkg::KWLEN_W'(KEYWORD_MAX))
              ? plm_pkg::KWLEN_W'(KEYWORD_MAX) : kwlen_ff;
      klen = len_cap;
      for (int i = KEYWORD_MAX - 1; i >= 0; i--) begin
         if ((plm_pkg::KWLEN_W'(i) < len_cap) &&
             (kw_ff[i*plm_pkg::TEXT_W +: plm_pkg::TEXT_W] == plm_pkg::CHAR_NUL)) begin
            klen = plm_pkg::KWLEN_W'(i);
         end
      end
   end

   always_comb begin
      kw_idx  = (phase_ff == PH_SKIP1) ? '0 : index_ff;
      kw_char = '0;
      for (int i = 0; i < KEYWORD_MAX; i++) begin
         if (kw_idx == plm_pkg::INDEX_W'(i)) begin
            kw_char = kw_ff[i*plm_pkg::TEXT_W +: plm_pkg::TEXT_W];
         end
      end
      pragma_char = '0;
      for (int i = 0; i < plm_pkg::PRAGMA_LEN; i++) begin
         if (index_ff == plm_pkg::INDEX_W'(i)) begin
            pragma_char = plm_pkg::PRAGMA_WORD[i*plm_pkg::TEXT_W +: plm_pkg::TEXT_W];
         end
      end
   end

   assign cur_line = (line_ff == plm_pkg::LINE_MAX) ? plm_pkg::LINE_MAX
                   : line_ff + plm_pkg::LINE_W'(1);
   assign is_blank = (in_byte_ff == plm_pkg::CHAR_TAB) || (in_byte_ff == plm_pkg::CHAR_SPACE);
   assign kw_hit   = (plm_pkg::KWLEN_W'(kw_idx) < klen) && (in_byte_ff == kw_char);
   assign kw_next  = kw_idx + plm_pkg::INDEX_W'(1);

   always_comb begin
      phase_in    = phase_ff;
      index_in    = index_ff;
      line_in     = line_ff;
      res_valid   = 1'b0;
      out_kind_in = plm_pkg::KIND_ARG;
      out_byte_in = in_byte_ff;
      out_line_in = cur_line;
      priority if (in_byte_ff == plm_pkg::CHAR_NEWLINE) begin
         res_valid   = (phase_ff == PH_ARG) || (phase_ff == PH_ARGCUT);
         out_kind_in = plm_pkg::KIND_END;
         out_byte_in = '0;
         line_in     = cur_line;
         phase_in    = PH_LEAD;
         index_in    = '0;
      end else if (in_byte_ff == plm_pkg::CHAR_NUL) begin
         phase_in = ((phase_ff == PH_ARG) || (phase_ff == PH_ARGCUT)) ? PH_ARGCUT : PH_DEAD;
      end else begin
         unique case (phase_ff)
            PH_LEAD: begin
               if (!is_blank) begin
                  phase_in = (in_byte_ff == plm_pkg::CHAR_HASH) ? PH_POSTHASH : PH_DEAD;
               end
            end
            PH_POSTHASH: begin
               if (!is_blank) begin
                  if (in_byte_ff == plm_pkg::PRAGMA_WORD[plm_pkg::TEXT_W-1:0]) begin
                     phase_in = PH_PRAGMA;
                     index_in = plm_pkg::INDEX_W'(1);
                  end else begin
                     phase_in = PH_DEAD;
                  end
               end
            end
            PH_PRAGMA: begin
               if ((index_ff < plm_pkg::INDEX_W'(plm_pkg::PRAGMA_LEN)) &&
                   (in_byte_ff == pragma_char)) begin
                  if (index_ff == plm_pkg::INDEX_W'(plm_pkg::PRAGMA_LEN - 1)) begin
                     phase_in = PH_NEEDBLANK1;
                     index_in = '0;
                  end else begin
                     index_in = index_ff + plm_pkg::INDEX_W'(1);
                  end
               end else begin
                  phase_in = PH_DEAD;
               end
            end
            PH_NEEDBLANK1: begin
               phase_in = is_blank ? PH_SKIP1 : PH_DEAD;
            end
            PH_SKIP1, PH_KEYWORD: begin
               if (!is_blank || (phase_ff == PH_KEYWORD)) begin
                  index_in = kw_idx;
                  if (kw_hit) begin
                     index_in = kw_next;
                     phase_in = (plm_pkg::KWLEN_W'(kw_next) >= klen) ? PH_NEEDBLANK2
                                                                     : PH_KEYWORD;
                  end else begin
                     phase_in = PH_DEAD;
                  end
               end
            end
            PH_NEEDBLANK2: begin
               phase_in = is_blank ? PH_SKIP2 : PH_DEAD;
            end
            PH_SKIP2: begin
               if (!is_blank) begin
                  phase_in  = PH_ARG;
                  res_valid = 1'b1;
               end
            end
            PH_ARG: begin
               res_valid = 1'b1;
            end
            PH_ARGCUT: begin
               phase_in = PH_ARGCUT;
            end
            default: begin
               phase_in = PH_DEAD;
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      if (advance) begin
         out_valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kw_ff        <= '0;
         kwlen_ff     <= plm_pkg::KWLEN_W'(1);
         phase_ff     <= PH_LEAD;
         index_ff     <= '0;
         line_ff      <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (plm_pkg::csr_index_type'(csr_index))
               plm_pkg::CSR_KEYWORD_BYTES:  kw_ff    <= csr_wdata[KW_W-1:0];
               plm_pkg::CSR_KEYWORD_LENGTH: kwlen_ff <= csr_wdata[plm_pkg::KWLEN_W-1:0];
               default: ;
            endcase
         end
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            phase_ff <= phase_in;
            index_ff <= index_in;
            line_ff  <= line_in;
         end
         out_valid_ff <= out_valid_in;
      end
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.text_byte;
      end
      if (advance && res_valid) begin
         out_kind_ff <= out_kind_in;
         out_byte_ff <= out_byte_in;
         out_line_ff <= out_line_in;
      end
   end

`ifndef SYNTHESIS
   a_line_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (line_ff >= $past(line_ff)))
      else $error("line count went backward");

   a_end_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_kind_ff == plm_pkg::KIND_END)) |-> (out_byte_ff == '0))
      else $error("end marker carries a nonzero byte");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (advance && res_valid) |->
         ((phase_ff == PH_ARG) || (phase_ff == PH_ARGCUT) || (phase_ff == PH_SKIP2)))
      else $error("result produced outside the argument phases");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_bus.ready) |=> in_valid_ff)
      else $error("input register dropped a byte under stall");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_bus.ready)
      else $error("input register empty but not ready");
`endif

endmodule

`default_nettype wire
